// File: hdl/tfcc_pkg.sv
// ----------------------------------------------------------------------------
// tfcc_pkg
// Shared constants, types and the CRC-8 step for the thermal frame checker.
// ----------------------------------------------------------------------------
package tfcc_pkg;

  localparam int unsigned PIXELS   = 16;
  localparam int unsigned WORDS    = PIXELS + 1;
  localparam int unsigned DATA_LEN = 2 * WORDS;
  localparam int unsigned POS_W    = $clog2(DATA_LEN + 1);
  localparam int unsigned ADDR_W   = $clog2(WORDS);
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned WORD_W   = 16;

  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [6:0] BUS_ADDR_RST = 7'h0A;
  localparam logic [7:0] CMD_CODE_RST = 8'h4C;

  localparam logic [7:0] CFG_IDX_BUS_ADDR = 8'd0;
  localparam logic [7:0] CFG_IDX_CMD_CODE = 8'd1;

  typedef struct packed {
    logic              crc_en;
    logic              seed_sel;
    logic              hold_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              load_err;
    logic              load_word;
    logic [ADDR_W-1:0] rd_addr;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic seed_ok;
    logic crc_match;
  } sts_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/tfcc_ctrl.sv
// ----------------------------------------------------------------------------
// tfcc_ctrl
// Frame sequencer: byte position, frame activity, result burst and output
// valid.
// ----------------------------------------------------------------------------
module tfcc_ctrl import tfcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic frame_start_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_q, state_d;
  logic              active_q, active_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic              out_valid_q, out_valid_d;

  logic in_acc, out_free, at_pec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign at_pec     = active_q && (pos_q == POS_W'(DATA_LEN));
  assign in_ready_o = (state_q == ST_RUN) && sts_i.seed_ok && !(at_pec && !out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    pos_d       = pos_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_RUN: begin
        if (in_acc) begin
          if (frame_start_i) begin
            cmd_o.crc_en   = 1'b1;
            cmd_o.seed_sel = 1'b1;
            cmd_o.hold_en  = 1'b1;
            active_d       = 1'b1;
            pos_d          = POS_W'(1);
          end else if (active_q) begin
            if (!at_pec) begin
              cmd_o.crc_en  = 1'b1;
              cmd_o.hold_en = !pos_q[0];
              cmd_o.wr_en   = pos_q[0];
              cmd_o.wr_addr = pos_q[ADDR_W:1];
              pos_d         = pos_q + POS_W'(1);
            end else begin
              active_d = 1'b0;
              if (sts_i.crc_match) begin
                state_d = ST_EMIT;
                k_d     = '0;
              end else begin
                cmd_o.load_err = 1'b1;
                out_valid_d    = 1'b1;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_word = 1'b1;
          cmd_o.rd_addr   = k_q;
          cmd_o.last      = (k_q == ADDR_W'(WORDS - 1));
          out_valid_d     = 1'b1;
          k_d             = k_q + ADDR_W'(1);
          if (cmd_o.last) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      active_q    <= 1'b0;
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/tfcc_datapath.sv
// ----------------------------------------------------------------------------
// tfcc_datapath
// Config registers, staged CRC seed, running CRC, word packing, word store
// and output payload registers.
// ----------------------------------------------------------------------------
module tfcc_datapath import tfcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [7:0]        data_byte_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [IDX_W-1:0]  word_index_o,
  output logic [WORD_W-1:0] word_value_o,
  output logic              crc_ok_o,
  output logic              last_o
);

  logic [6:0]        bus_addr_q;
  logic [7:0]        cmd_code_q;
  logic [7:0]        c1_q, c2_q, seed_q;
  logic [1:0]        settle_q;
  logic [7:0]        crc_q;
  logic [7:0]        hold_q;
  logic [WORD_W-1:0] store [WORDS];
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] value_q;
  logic              ok_q, last_q;

  logic [7:0] wr_byte;
  logic [7:0] crc_d;

  assign wr_byte = {bus_addr_q, 1'b0};
  assign crc_d   = crc_byte(data_byte_i ^ (cmd_i.seed_sel ? seed_q : crc_q));

  assign sts_o.seed_ok   = (settle_q == 2'd0);
  assign sts_o.crc_match = (crc_q == data_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_addr_q <= BUS_ADDR_RST;
      cmd_code_q <= CMD_CODE_RST;
      settle_q   <= 2'd3;
      c1_q       <= '0;
      c2_q       <= '0;
      seed_q     <= '0;
      crc_q      <= '0;
      hold_q     <= '0;
    end else begin
      c1_q   <= crc_byte(wr_byte);
      c2_q   <= crc_byte(cmd_code_q ^ c1_q);
      seed_q <= crc_byte((wr_byte | 8'h01) ^ c2_q);
      if (cfg_valid_i) begin
        settle_q <= 2'd3;
        unique case (cfg_index_i)
          CFG_IDX_BUS_ADDR: bus_addr_q <= cfg_data_i[6:0];
          CFG_IDX_CMD_CODE: cmd_code_q <= cfg_data_i;
          default: ;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      if (cmd_i.crc_en) begin
        crc_q <= crc_d;
      end
      if (cmd_i.hold_en) begin
        hold_q <= data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store[cmd_i.wr_addr] <= {data_byte_i, hold_q};
    end
    if (cmd_i.load_word) begin
      value_q <= store[cmd_i.rd_addr];
      idx_q   <= IDX_W'(cmd_i.rd_addr);
      ok_q    <= 1'b1;
      last_q  <= cmd_i.last;
    end else if (cmd_i.load_err) begin
      value_q <= '0;
      idx_q   <= '0;
      ok_q    <= 1'b0;
      last_q  <= 1'b1;
    end
  end

  assign word_index_o = idx_q;
  assign word_value_o = value_q;
  assign crc_ok_o     = ok_q;
  assign last_o       = last_q;

endmodule

// File: hdl/thermal_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// thermal_frame_crc_checker
// Checks the PEC of a byte-serial thermal sensor frame and unpacks its words.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o   data_byte_i, frame_start_i
//   out      out        out_valid_o/out_ready_i word_index_o, word_value_o,
//                                               crc_ok_o, last_o
//
// One byte per cycle. A good PEC starts a burst of PIXELS+1 results, one per
// unstalled cycle out of the word store; no byte is taken during the burst.
// After reset and after each config transaction the staged CRC seed settles
// through c1_q, c2_q and seed_q; in_ready_o stays low meanwhile.
// A PEC byte waits while an earlier result is stalled in the output register.
// ----------------------------------------------------------------------------
module thermal_frame_crc_checker import tfcc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [7:0]               cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     frame_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         word_index_o,
  output logic signed [WORD_W-1:0] word_value_o,
  output logic                     crc_ok_o,
  output logic                     last_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] value;

  assign cfg_ready_o  = 1'b1;
  assign word_value_o = $signed(value);

  tfcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tfcc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .data_byte_i  (data_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .word_index_o (word_index_o),
    .word_value_o (value),
    .crc_ok_o     (crc_ok_o),
    .last_o       (last_o)
  );

endmodule

// File: hdl/tfcc_checker.sv
// ----------------------------------------------------------------------------
// tfcc_checker
// Port-level checks for the thermal frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module tfcc_checker import tfcc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [IDX_W-1:0]         word_index_o,
  input logic signed [WORD_W-1:0] word_value_o,
  input logic                     crc_ok_o,
  input logic                     last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(word_index_o) && $stable(word_value_o) &&
      $stable(crc_ok_o) && $stable(last_o))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crc_ok_o |-> last_o && word_index_o == '0 && word_value_o == '0)
    else $error("malformed error result");

  a_burst_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && crc_ok_o && !last_o |=>
      out_valid_o && crc_ok_o &&
      word_index_o == IDX_W'($past(word_index_o) + IDX_W'(1)))
    else $error("burst gap or index skip");

  a_seed_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("byte taken before seed settled");

endmodule

bind thermal_frame_crc_checker tfcc_checker u_tfcc_checker (.*);
